FILE: rtl/glrb_pkg.sv
// Shared types, constants and arithmetic helpers for the glyph run layout and bounds unit.
// Used by every module in rtl; depends on nothing else.
package glrb_pkg;

	localparam int COORD_BITS     = 32;
	localparam int FONT_UNIT_BITS = 16;
	localparam int CW             = (COORD_BITS < 32) ? COORD_BITS : 32;
	localparam int SLOT_BITS      = 16;
	localparam int SCALE_BITS     = 24;
	localparam int PW             = FONT_UNIT_BITS + SCALE_BITS + 1;

	localparam logic [SCALE_BITS-1:0] SCALE_RESET = SCALE_BITS'(65536);

	typedef logic signed [CW-1:0] coord_t;

	localparam coord_t CMAX = {1'b0, {(CW-1){1'b1}}};
	localparam coord_t CMIN = {1'b1, {(CW-1){1'b0}}};

	typedef struct packed {
		coord_t mn_x;
		coord_t mn_y;
		coord_t mx_x;
		coord_t mx_y;
	} box_t;

	// One glyph as it arrives on the input channel.
	typedef struct packed {
		logic [15:0]        glyph_id;
		logic [31:0]        offset_xy;
		logic [31:0]        advance_xy;
		logic signed [15:0] ink_min_x;
		logic signed [15:0] ink_min_y;
		logic signed [15:0] ink_max_x;
		logic signed [15:0] ink_max_y;
		logic signed [15:0] plane_min_x;
		logic signed [15:0] plane_min_y;
		logic signed [15:0] plane_max_x;
		logic signed [15:0] plane_max_y;
		logic               last_glyph;
	} raw_t;

	// Scaled to world units, not yet placed.
	typedef struct packed {
		logic [15:0] glyph_id;
		logic        last;
		coord_t      off_x;
		coord_t      off_y;
		coord_t      adv_x;
		coord_t      adv_y;
		box_t        ink;
		box_t        plane;
	} scl_t;

	// Origin and pen known; boxes still relative to the origin.
	typedef struct packed {
		logic [15:0] glyph_id;
		logic        last;
		coord_t      org_x;
		coord_t      org_y;
		coord_t      adv_x;
		coord_t      adv_y;
		coord_t      pen_x;
		coord_t      pen_y;
		box_t        ink;
		box_t        plane;
	} plc_t;

	typedef struct packed {
		logic        record_kind;
		logic [15:0] glyph_id;
		logic [63:0] origin_xy;
		logic [63:0] advance_xy;
		logic [63:0] ink_min_xy;
		logic [63:0] ink_max_xy;
		logic [63:0] plane_min_xy;
		logic [63:0] plane_max_xy;
		logic        last_result;
	} rec_t;

	function automatic coord_t sat_prod(logic signed [PW-1:0] p);
		logic [PW-CW:0] top;
		top = p[PW-1:CW-1];
		if ((&top) || !(|top)) begin
			return p[CW-1:0];
		end
		return p[PW-1] ? CMIN : CMAX;
	endfunction

	function automatic coord_t sat_sum(coord_t a, coord_t b);
		logic signed [CW:0] s;
		s = {a[CW-1], a} + {b[CW-1], b};
		if (s[CW] == s[CW-1]) begin
			return s[CW-1:0];
		end
		return s[CW] ? CMIN : CMAX;
	endfunction

	// A font unit value is the low FONT_UNIT_BITS of its slot, sign extended,
	// times the unsigned Q8.16 scale. The product is exact before saturation.
	function automatic coord_t scale_slot(logic [SLOT_BITS-1:0] slot,
	                                      logic [SCALE_BITS-1:0] s);
		logic signed [FONT_UNIT_BITS-1:0] f;
		logic signed [PW-1:0] fe;
		logic signed [PW-1:0] se;
		f  = slot[FONT_UNIT_BITS-1:0];
		fe = PW'(f);
		se = PW'({1'b0, s});
		return sat_prod(fe * se);
	endfunction

	function automatic logic [63:0] pack_xy(coord_t x, coord_t y);
		logic signed [31:0] xs;
		logic signed [31:0] ys;
		xs = x;
		ys = y;
		return {ys, xs};
	endfunction

endpackage

FILE: rtl/glrb_if.sv
// Channel interfaces of the glyph run layout and bounds unit: glyph input and record output.
// Standalone; no package dependency.
interface glrb_glyph_if;
	logic        valid;
	logic        ready;
	logic [15:0] glyph_id;
	logic [31:0] offset_xy;
	logic [31:0] advance_xy;
	logic signed [15:0] ink_min_x;
	logic signed [15:0] ink_min_y;
	logic signed [15:0] ink_max_x;
	logic signed [15:0] ink_max_y;
	logic signed [15:0] plane_min_x;
	logic signed [15:0] plane_min_y;
	logic signed [15:0] plane_max_x;
	logic signed [15:0] plane_max_y;
	logic        last_glyph;

	modport source (output valid, glyph_id, offset_xy, advance_xy, ink_min_x, ink_min_y,
		ink_max_x, ink_max_y, plane_min_x, plane_min_y, plane_max_x, plane_max_y,
		last_glyph, input ready);
	modport sink (input valid, glyph_id, offset_xy, advance_xy, ink_min_x, ink_min_y,
		ink_max_x, ink_max_y, plane_min_x, plane_min_y, plane_max_x, plane_max_y,
		last_glyph, output ready);
endinterface

interface glrb_rec_if;
	logic        valid;
	logic        ready;
	logic        record_kind;
	logic [15:0] out_glyph_id;
	logic [63:0] origin_xy;
	logic [63:0] advance_out_xy;
	logic [63:0] ink_min_xy;
	logic [63:0] ink_max_xy;
	logic [63:0] plane_min_xy;
	logic [63:0] plane_max_xy;
	logic        last_result;

	modport source (output valid, record_kind, out_glyph_id, origin_xy, advance_out_xy,
		ink_min_xy, ink_max_xy, plane_min_xy, plane_max_xy, last_result, input ready);
	modport sink (input valid, record_kind, out_glyph_id, origin_xy, advance_out_xy,
		ink_min_xy, ink_max_xy, plane_min_xy, plane_max_xy, last_result, output ready);
endinterface

FILE: rtl/glrb_cfg.sv
// APB-style configuration register file: holds world_scale.
// Depends on glrb_pkg.
module glrb_cfg import glrb_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [2:0]            paddr,
	input  logic [31:0]           pwdata,
	output logic [31:0]           prdata,
	output logic                  pready,
	output logic [SCALE_BITS-1:0] world_scale
);

	typedef enum logic [0:0] {
		REG_WORLD_SCALE = 1'b0
	} reg_idx_t;

	logic [SCALE_BITS-1:0] scale_q;
	reg_idx_t idx;
	logic wr;

	assign idx         = reg_idx_t'(paddr[2]);
	assign wr          = psel && penable && pwrite;
	assign pready      = 1'b1;
	assign world_scale = scale_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scale_q <= SCALE_RESET;
		end else if (wr && idx == REG_WORLD_SCALE) begin
			scale_q <= pwdata[SCALE_BITS-1:0];
		end
	end

	always_comb begin
		unique case (idx)
			REG_WORLD_SCALE: prdata = 32'(scale_q);
			default:         prdata = '0;
		endcase
	end

endmodule

FILE: rtl/glrb_scale.sv
// Input register and scaling stage: twelve saturating font unit by scale products per glyph.
// Depends on glrb_pkg.
module glrb_scale import glrb_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic [SCALE_BITS-1:0] world_scale,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  raw_t                  in_data,
	output logic                  out_valid,
	input  logic                  out_ready,
	output scl_t                  out_data
);

	logic v_s1, v_s2;
	logic en_s1, en_s2;
	raw_t raw_s1;
	scl_t scl_s2;
	scl_t scl_d;

	assign en_s2    = !v_s2 || out_ready;
	assign en_s1    = !v_s1 || en_s2;
	assign in_ready = en_s1;

	always_comb begin
		scl_d.glyph_id    = raw_s1.glyph_id;
		scl_d.last        = raw_s1.last_glyph;
		scl_d.off_x       = scale_slot(raw_s1.offset_xy[15:0], world_scale);
		scl_d.off_y       = scale_slot(raw_s1.offset_xy[31:16], world_scale);
		scl_d.adv_x       = scale_slot(raw_s1.advance_xy[15:0], world_scale);
		scl_d.adv_y       = scale_slot(raw_s1.advance_xy[31:16], world_scale);
		scl_d.ink.mn_x    = scale_slot(raw_s1.ink_min_x, world_scale);
		scl_d.ink.mn_y    = scale_slot(raw_s1.ink_min_y, world_scale);
		scl_d.ink.mx_x    = scale_slot(raw_s1.ink_max_x, world_scale);
		scl_d.ink.mx_y    = scale_slot(raw_s1.ink_max_y, world_scale);
		scl_d.plane.mn_x  = scale_slot(raw_s1.plane_min_x, world_scale);
		scl_d.plane.mn_y  = scale_slot(raw_s1.plane_min_y, world_scale);
		scl_d.plane.mx_x  = scale_slot(raw_s1.plane_max_x, world_scale);
		scl_d.plane.mx_y  = scale_slot(raw_s1.plane_max_y, world_scale);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (en_s1) begin
				v_s1 <= in_valid;
			end
			if (en_s2) begin
				v_s2 <= v_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1 && in_valid) begin
			raw_s1 <= in_data;
		end
		if (en_s2 && v_s1) begin
			scl_s2 <= scl_d;
		end
	end

	assign out_valid = v_s2;
	assign out_data  = scl_s2;

endmodule

FILE: rtl/glrb_place.sv
// Placement stages: running pen, glyph origin, then box corners in world space.
// Depends on glrb_pkg.
module glrb_place import glrb_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  scl_t in_data,
	output logic out_valid,
	input  logic out_ready,
	output plc_t out_data
);

	logic v_s3, v_s4;
	logic en_s3, en_s4;
	coord_t pen_x_q, pen_y_q;
	coord_t pen_x_d, pen_y_d;
	plc_t plc_s3, plc_s4;
	plc_t plc_d3, plc_d4;

	assign en_s4    = !v_s4 || out_ready;
	assign en_s3    = !v_s3 || en_s4;
	assign in_ready = en_s3;

	assign pen_x_d = sat_sum(pen_x_q, in_data.adv_x);
	assign pen_y_d = sat_sum(pen_y_q, in_data.adv_y);

	always_comb begin
		plc_d3.glyph_id = in_data.glyph_id;
		plc_d3.last     = in_data.last;
		plc_d3.org_x    = sat_sum(pen_x_q, in_data.off_x);
		plc_d3.org_y    = sat_sum(pen_y_q, in_data.off_y);
		plc_d3.adv_x    = in_data.adv_x;
		plc_d3.adv_y    = in_data.adv_y;
		plc_d3.pen_x    = pen_x_d;
		plc_d3.pen_y    = pen_y_d;
		plc_d3.ink      = in_data.ink;
		plc_d3.plane    = in_data.plane;
	end

	always_comb begin
		plc_d4            = plc_s3;
		plc_d4.ink.mn_x   = sat_sum(plc_s3.org_x, plc_s3.ink.mn_x);
		plc_d4.ink.mn_y   = sat_sum(plc_s3.org_y, plc_s3.ink.mn_y);
		plc_d4.ink.mx_x   = sat_sum(plc_s3.org_x, plc_s3.ink.mx_x);
		plc_d4.ink.mx_y   = sat_sum(plc_s3.org_y, plc_s3.ink.mx_y);
		plc_d4.plane.mn_x = sat_sum(plc_s3.org_x, plc_s3.plane.mn_x);
		plc_d4.plane.mn_y = sat_sum(plc_s3.org_y, plc_s3.plane.mn_y);
		plc_d4.plane.mx_x = sat_sum(plc_s3.org_x, plc_s3.plane.mx_x);
		plc_d4.plane.mx_y = sat_sum(plc_s3.org_y, plc_s3.plane.mx_y);
	end

	// The pen returns to the origin once the last glyph of a run has passed.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3    <= 1'b0;
			v_s4    <= 1'b0;
			pen_x_q <= '0;
			pen_y_q <= '0;
		end else begin
			if (en_s3) begin
				v_s3 <= in_valid;
			end
			if (en_s4) begin
				v_s4 <= v_s3;
			end
			if (en_s3 && in_valid) begin
				pen_x_q <= in_data.last ? '0 : pen_x_d;
				pen_y_q <= in_data.last ? '0 : pen_y_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en_s3 && in_valid) begin
			plc_s3 <= plc_d3;
		end
		if (en_s4 && v_s3) begin
			plc_s4 <= plc_d4;
		end
	end

	assign out_valid = v_s4;
	assign out_data  = plc_s4;

	a_pen_cleared_after_run: assert property (@(posedge clk) disable iff (!arst_n)
		(en_s3 && in_valid && in_data.last) |=> (pen_x_q == '0 && pen_y_q == '0))
		else $error("pen not cleared after the last glyph of a run");

endmodule

FILE: rtl/glrb_bounds.sv
// Running ink and plane bounds, glyph record register and run summary register.
// Depends on glrb_pkg.
module glrb_bounds import glrb_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  plc_t in_data,
	output logic out_valid,
	input  logic out_ready,
	output rec_t out_data
);

	localparam logic KIND_GLYPH   = 1'b0;
	localparam logic KIND_SUMMARY = 1'b1;

	localparam box_t BOX_EMPTY = '{mn_x: CMAX, mn_y: CMAX, mx_x: CMIN, mx_y: CMIN};

	box_t run_ink_q, run_plane_q;
	logic ink_seen_q, plane_seen_q;
	logic out_v_q, sum_v_q;
	rec_t out_q, sum_q;

	logic load;
	logic ink_vis, plane_vis;
	logic ink_seen_d, plane_seen_d;
	box_t run_ink_d, run_plane_d;
	box_t sum_ink, sum_plane;
	rec_t glyph_rec, sum_rec;

	function automatic logic visible(box_t b);
		return (b.mx_x > b.mn_x) && (b.mx_y > b.mn_y);
	endfunction

	function automatic box_t join_box(box_t run, box_t b, logic vis);
		box_t r;
		r = run;
		if (vis) begin
			if (b.mn_x < run.mn_x) r.mn_x = b.mn_x;
			if (b.mn_y < run.mn_y) r.mn_y = b.mn_y;
			if (b.mx_x > run.mx_x) r.mx_x = b.mx_x;
			if (b.mx_y > run.mx_y) r.mx_y = b.mx_y;
		end
		return r;
	endfunction

	// A summary waits behind its glyph record, so nothing new enters while it is held.
	assign in_ready = !out_v_q || (out_ready && !sum_v_q);
	assign load     = in_valid && in_ready;

	always_comb begin
		ink_vis      = visible(in_data.ink);
		plane_vis    = visible(in_data.plane);
		ink_seen_d   = ink_seen_q || ink_vis;
		plane_seen_d = plane_seen_q || plane_vis;
		run_ink_d    = join_box(run_ink_q, in_data.ink, ink_vis);
		run_plane_d  = join_box(run_plane_q, in_data.plane, plane_vis);

		// Without visible ink the box spans the origin and the final pen.
		if (ink_seen_d) begin
			sum_ink = run_ink_d;
		end else begin
			sum_ink.mn_x = in_data.pen_x[CW-1] ? in_data.pen_x : '0;
			sum_ink.mn_y = in_data.pen_y[CW-1] ? in_data.pen_y : '0;
			sum_ink.mx_x = in_data.pen_x[CW-1] ? '0 : in_data.pen_x;
			sum_ink.mx_y = in_data.pen_y[CW-1] ? '0 : in_data.pen_y;
		end
		sum_plane = plane_seen_d ? run_plane_d : sum_ink;

		glyph_rec.record_kind  = KIND_GLYPH;
		glyph_rec.glyph_id     = in_data.glyph_id;
		glyph_rec.origin_xy    = pack_xy(in_data.org_x, in_data.org_y);
		glyph_rec.advance_xy   = pack_xy(in_data.adv_x, in_data.adv_y);
		glyph_rec.ink_min_xy   = pack_xy(in_data.ink.mn_x, in_data.ink.mn_y);
		glyph_rec.ink_max_xy   = pack_xy(in_data.ink.mx_x, in_data.ink.mx_y);
		glyph_rec.plane_min_xy = pack_xy(in_data.plane.mn_x, in_data.plane.mn_y);
		glyph_rec.plane_max_xy = pack_xy(in_data.plane.mx_x, in_data.plane.mx_y);
		glyph_rec.last_result  = !in_data.last;

		sum_rec.record_kind  = KIND_SUMMARY;
		sum_rec.glyph_id     = '0;
		sum_rec.origin_xy    = '0;
		sum_rec.advance_xy   = pack_xy(in_data.pen_x, in_data.pen_y);
		sum_rec.ink_min_xy   = pack_xy(sum_ink.mn_x, sum_ink.mn_y);
		sum_rec.ink_max_xy   = pack_xy(sum_ink.mx_x, sum_ink.mx_y);
		sum_rec.plane_min_xy = pack_xy(sum_plane.mn_x, sum_plane.mn_y);
		sum_rec.plane_max_xy = pack_xy(sum_plane.mx_x, sum_plane.mx_y);
		sum_rec.last_result  = 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_ink_q    <= BOX_EMPTY;
			run_plane_q  <= BOX_EMPTY;
			ink_seen_q   <= 1'b0;
			plane_seen_q <= 1'b0;
			out_v_q      <= 1'b0;
			sum_v_q      <= 1'b0;
		end else begin
			if (load) begin
				run_ink_q    <= in_data.last ? BOX_EMPTY : run_ink_d;
				run_plane_q  <= in_data.last ? BOX_EMPTY : run_plane_d;
				ink_seen_q   <= in_data.last ? 1'b0 : ink_seen_d;
				plane_seen_q <= in_data.last ? 1'b0 : plane_seen_d;
				out_v_q      <= 1'b1;
				sum_v_q      <= in_data.last;
			end else if (out_v_q && out_ready) begin
				if (sum_v_q) begin
					sum_v_q <= 1'b0;
				end else begin
					out_v_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_q <= glyph_rec;
			if (in_data.last) begin
				sum_q <= sum_rec;
			end
		end else if (out_v_q && out_ready && sum_v_q) begin
			out_q <= sum_q;
		end
	end

	assign out_valid = out_v_q;
	assign out_data  = out_q;

	a_summary_behind_glyph: assert property (@(posedge clk) disable iff (!arst_n)
		sum_v_q |-> (out_v_q && out_q.record_kind == KIND_GLYPH && !out_q.last_result))
		else $error("held summary is not behind its glyph record");

	a_summary_follows_last: assert property (@(posedge clk) disable iff (!arst_n)
		(load && in_data.last) |=> (sum_v_q && sum_q.record_kind == KIND_SUMMARY))
		else $error("no summary held after the last glyph");

	a_run_flags_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		(load && in_data.last) |=> (!ink_seen_q && !plane_seen_q))
		else $error("run flags not cleared at end of run");

endmodule

FILE: rtl/glyph_run_layout_bounds_unit.sv
// Glyph run layout and bounds unit, top level. Accepts one glyph transfer per cycle unless
// held by record back-pressure or a pending summary. Each glyph passes five registers (input,
// scale products, origin and pen, box corners, record) before its placement record is valid.
// The last glyph of a run is followed by a summary record once its glyph record is taken;
// while the summary is held the record stage takes nothing new, so a run of N glyphs leaves
// as N+1 records. The one saturating pen add per axis per glyph keeps the loop at one glyph
// per cycle when nothing stalls. world_scale may only be written while the unit is empty.
// Depends on glrb_pkg, glrb_if, glrb_cfg, glrb_scale, glrb_place and glrb_bounds.
module glyph_run_layout_bounds_unit import glrb_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	glrb_glyph_if.sink    glyph,
	glrb_rec_if.source    record,
	input  logic          psel,
	input  logic          penable,
	input  logic          pwrite,
	input  logic [2:0]    paddr,
	input  logic [31:0]   pwdata,
	output logic [31:0]   prdata,
	output logic          pready
);

	logic [SCALE_BITS-1:0] world_scale;
	raw_t raw;
	scl_t scl;
	plc_t plc;
	rec_t rec;
	logic scl_v, scl_r, plc_v, plc_r;

	glrb_cfg u_cfg (
		.clk         (clk),
		.arst_n      (arst_n),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.prdata      (prdata),
		.pready      (pready),
		.world_scale (world_scale)
	);

	always_comb begin
		raw.glyph_id    = glyph.glyph_id;
		raw.offset_xy   = glyph.offset_xy;
		raw.advance_xy  = glyph.advance_xy;
		raw.ink_min_x   = glyph.ink_min_x;
		raw.ink_min_y   = glyph.ink_min_y;
		raw.ink_max_x   = glyph.ink_max_x;
		raw.ink_max_y   = glyph.ink_max_y;
		raw.plane_min_x = glyph.plane_min_x;
		raw.plane_min_y = glyph.plane_min_y;
		raw.plane_max_x = glyph.plane_max_x;
		raw.plane_max_y = glyph.plane_max_y;
		raw.last_glyph  = glyph.last_glyph;
	end

	glrb_scale u_scale (
		.clk         (clk),
		.arst_n      (arst_n),
		.world_scale (world_scale),
		.in_valid    (glyph.valid),
		.in_ready    (glyph.ready),
		.in_data     (raw),
		.out_valid   (scl_v),
		.out_ready   (scl_r),
		.out_data    (scl)
	);

	glrb_place u_place (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (scl_v),
		.in_ready  (scl_r),
		.in_data   (scl),
		.out_valid (plc_v),
		.out_ready (plc_r),
		.out_data  (plc)
	);

	glrb_bounds u_bounds (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (plc_v),
		.in_ready  (plc_r),
		.in_data   (plc),
		.out_valid (record.valid),
		.out_ready (record.ready),
		.out_data  (rec)
	);

	assign record.record_kind    = rec.record_kind;
	assign record.out_glyph_id   = rec.glyph_id;
	assign record.origin_xy      = rec.origin_xy;
	assign record.advance_out_xy = rec.advance_xy;
	assign record.ink_min_xy     = rec.ink_min_xy;
	assign record.ink_max_xy     = rec.ink_max_xy;
	assign record.plane_min_xy   = rec.plane_min_xy;
	assign record.plane_max_xy   = rec.plane_max_xy;
	assign record.last_result    = rec.last_result;

endmodule
